/* rtl/ddpt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the differential-drive pose tracker.
package ddpt_pkg;

  localparam int MulAW = 40;
  localparam int MulBW = 34;
  localparam int AccW  = 76;
  localparam int DivW  = 40;
  localparam int CorW  = 36;
  localparam int AngW  = 24;

  localparam logic signed [AngW-1:0] PiQ16     = 24'sd205887;
  localparam logic signed [AngW-1:0] HalfPiQ16 = 24'sd102944;
  localparam logic signed [AngW:0]   PiQ16W    = 25'sd205887;
  localparam logic signed [AngW:0]   TwoPiQ16  = 25'sd411774;
  localparam logic signed [CorW-1:0] CordicKQ30 = 36'sd652032874;

  localparam logic signed [DivW-1:0] TsBiasQ16 = 40'sd6554;
  localparam logic [DivW-1:0]        ExpNumQ32 = 40'd171798692;
  localparam logic signed [31:0]     ExpOneQ30 = 32'sd1073741824;
  localparam logic [3:0]             ExpTerms  = 4'd12;
  localparam logic [1:0]             LastSquare = 2'd3;
  localparam logic signed [MulBW-1:0] GainU0Q16 = 34'sd873813;
  localparam logic signed [MulBW-1:0] GainU1Q16 = 34'sd140684;
  localparam logic [15:0]            AlphaMax  = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_ODOM = 2'd0,
    REQ_GOAL = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic {
    COR_VECTOR = 1'b0,
    COR_ROTATE = 1'b1
  } cor_mode_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HEAD,
    S_MG_X,
    S_MG_Y,
    S_SQ_G,
    S_MR_X,
    S_MR_Y,
    S_SQ_R,
    S_DIV_A,
    S_EXP_MUL,
    S_EXP_DIV,
    S_SQR,
    S_ROT,
    S_FX1,
    S_FX2,
    S_FY1,
    S_FY2,
    S_U0A,
    S_U0B,
    S_U1A,
    S_U1B,
    S_RA,
    S_RB,
    S_LA,
    S_LB,
    S_OUT
  } state_e;

  typedef struct packed {
    logic go;
    logic clr;
    logic neg;
  } mul_ctrl_t;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [3:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      4'd0:    v = 24'sd51472;
      4'd1:    v = 24'sd30386;
      4'd2:    v = 24'sd16055;
      4'd3:    v = 24'sd8150;
      4'd4:    v = 24'sd4091;
      4'd5:    v = 24'sd2047;
      4'd6:    v = 24'sd1024;
      4'd7:    v = 24'sd512;
      4'd8:    v = 24'sd256;
      4'd9:    v = 24'sd128;
      4'd10:   v = 24'sd64;
      4'd11:   v = 24'sd32;
      4'd12:   v = 24'sd16;
      4'd13:   v = 24'sd8;
      4'd14:   v = 24'sd4;
      default: v = 24'sd2;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ddpt_mul.sv */
`timescale 1ns / 1ps
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module ddpt_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ddpt_pkg::mul_ctrl_t                   ctrl_i,
  input  logic signed [ddpt_pkg::MulAW-1:0]     a_i,
  input  logic signed [ddpt_pkg::MulBW-1:0]     b_i,
  output logic signed [ddpt_pkg::AccW-1:0]      acc_o,
  output logic                                  done_o
);

  localparam int CntW = $clog2(ddpt_pkg::MulBW);

  logic                               busy_q, done_q;
  logic [CntW-1:0]                    cnt_q;
  logic signed [ddpt_pkg::AccW-1:0]   a_q, acc_q, addend, acc_d;
  logic [ddpt_pkg::MulBW-1:0]         b_q;
  logic                               neg_q, last, sub;

  assign last   = (cnt_q == CntW'(ddpt_pkg::MulBW - 1));
  assign sub    = last ^ neg_q;
  assign addend = b_q[0] ? a_q : '0;
  assign acc_d  = sub ? (acc_q - addend) : (acc_q + addend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      a_q   <= ddpt_pkg::AccW'(a_i);
      b_q   <= b_i;
      neg_q <= ctrl_i.neg;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

/* rtl/ddpt_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider that produces one quotient bit per cycle.
module ddpt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ddpt_pkg::DivW-1:0]     num_i,
  input  logic [ddpt_pkg::DivW-1:0]     den_i,
  output logic [ddpt_pkg::DivW-1:0]     quot_o,
  output logic                          done_o
);

  localparam int CntW = $clog2(ddpt_pkg::DivW);

  logic                          busy_q, done_q;
  logic [CntW-1:0]               cnt_q;
  logic [ddpt_pkg::DivW-1:0]     rem_q, num_q, den_q;
  logic [ddpt_pkg::DivW:0]       trial, diff;
  logic                          fits;

  assign trial = {rem_q, num_q[ddpt_pkg::DivW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ddpt_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[ddpt_pkg::DivW-1:0] : trial[ddpt_pkg::DivW-1:0];
      num_q <= {num_q[ddpt_pkg::DivW-2:0], fits};
    end
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

/* rtl/ddpt_isqrt.sv */
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one root bit per cycle.
module ddpt_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q, r_q, bit_q, t;

  assign t = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_q <= v_q - t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

/* rtl/ddpt_cordic.sv */
`timescale 1ns / 1ps
// Iterative CORDIC for the heading angle and for its cosine and sine.
module ddpt_cordic (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  ddpt_pkg::cor_mode_e    mode_i,
  input  logic signed [15:0]     quat_z_i,
  input  logic signed [15:0]     quat_w_i,
  input  logic signed [15:0]     head_i,
  output logic signed [15:0]     head_o,
  output logic signed [17:0]     cos_o,
  output logic signed [17:0]     sin_o,
  output logic                   done_o
);

  localparam int CW = ddpt_pkg::CorW;
  localparam int AW = ddpt_pkg::AngW;

  logic                  busy_q, done_q;
  logic [3:0]            cnt_q;
  ddpt_pkg::cor_mode_e   mode_q;
  logic signed [CW-1:0]  x_q, y_q, xsh, ysh, xs, ys, xn, yn;
  logic signed [AW-1:0]  z_q, zh, at;
  logic                  neg_q, sig_pos;
  logic signed [AW:0]    a2, a2w, hr;
  logic signed [CW-1:0]  cr, sr;

  assign xs      = CW'(quat_w_i) <<< 16;
  assign ys      = CW'(quat_z_i) <<< 16;
  assign zh      = AW'(head_i) <<< 3;
  assign xsh     = x_q >>> cnt_q;
  assign ysh     = y_q >>> cnt_q;
  assign at      = ddpt_pkg::atan_tab(cnt_q);
  assign sig_pos = (mode_q == ddpt_pkg::COR_VECTOR) ? !(y_q > 0) : (z_q >= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      neg_q  <= 1'b0;
      if (mode_i == ddpt_pkg::COR_VECTOR) begin
        if (quat_w_i < 0) begin
          x_q <= -xs;
          y_q <= -ys;
          z_q <= (quat_z_i >= 0) ? ddpt_pkg::PiQ16 : -ddpt_pkg::PiQ16;
        end else begin
          x_q <= xs;
          y_q <= ys;
          z_q <= '0;
        end
      end else begin
        x_q <= ddpt_pkg::CordicKQ30;
        y_q <= '0;
        if (zh > ddpt_pkg::HalfPiQ16) begin
          z_q   <= zh - ddpt_pkg::PiQ16;
          neg_q <= 1'b1;
        end else if (zh < -ddpt_pkg::HalfPiQ16) begin
          z_q   <= zh + ddpt_pkg::PiQ16;
          neg_q <= 1'b1;
        end else begin
          z_q <= zh;
        end
      end
    end else if (busy_q) begin
      x_q <= xn;
      y_q <= yn;
      z_q <= sig_pos ? (z_q - at) : (z_q + at);
    end
  end

  assign xn = sig_pos ? (x_q - ysh) : (x_q + ysh);
  assign yn = sig_pos ? (y_q + xsh) : (y_q - xsh);

  always_comb begin
    a2 = (AW + 1)'(z_q) <<< 1;
    a2w = a2;
    if (a2w > ddpt_pkg::PiQ16W) begin
      a2w = a2w - ddpt_pkg::TwoPiQ16;
    end
    if (a2w < -ddpt_pkg::PiQ16W) begin
      a2w = a2w + ddpt_pkg::TwoPiQ16;
    end
    hr = a2w + 25'sd4;
  end

  assign head_o = hr[18:3];
  assign cr     = (neg_q ? -x_q : x_q) + 36'sd8192;
  assign sr     = (neg_q ? -y_q : y_q) + 36'sd8192;
  assign cos_o  = cr[31:14];
  assign sin_o  = sr[31:14];
  assign done_o = done_q;

endmodule

/* rtl/diff_drive_pose_tracker.sv */
`timescale 1ns / 1ps
// Top level of the differential-drive pose tracker and its sequencer.
//
// Words arrive on the input channel (in_valid_i / in_ready_o) and carry a
// request type, a position and a quaternion. An odometry word stores the robot
// pose, a goal word stores the goal and recomputes the smoothing factor, and a
// tick word filters the target and yields one output word with the right and
// left wheel speeds on the output channel (out_valid_o / out_ready_i).
// The block works on one word at a time; in_ready_o is high while the
// sequencer is idle. All arithmetic runs through one bit-serial multiplier,
// one bit-serial divider, a bit-serial square root and an iterative CORDIC.
// An odometry word with a zero quaternion clears the heading and skips the
// CORDIC; any other runs it. A goal word that runs the full exponential spends
// its time on the twelve series terms, each a product and a division; a tick
// word spends its time, until its output word is loaded, on twelve products.
// Reset clears the pose, the goal, the filter state and the smoothing factor.
// A finished output word waits in its register while new words are accepted;
// a tick that finishes while that register is still full holds until it is
// taken.
module diff_drive_pose_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] right_wheel_speed_o,
  output logic signed [31:0] left_wheel_speed_o
);

  localparam int AW = ddpt_pkg::MulAW;
  localparam int BW = ddpt_pkg::MulBW;
  localparam int CW = ddpt_pkg::AccW;
  localparam int DW = ddpt_pkg::DivW;

  ddpt_pkg::state_e state_q, state_d;
  logic             issued_q, issued_d;
  logic             in_fire, launch, unit_done, zero_quat;

  logic signed [31:0] robot_x_q, robot_y_q, goal_x_q, goal_y_q, ftx_q, fty_q;
  logic signed [15:0] heading_q;
  logic [15:0]        alpha_q;
  logic signed [15:0] quat_z_q, quat_w_q;

  logic [31:0]        magg_q, v_q;
  logic signed [DW-1:0] denom_q, denom;
  logic [19:0]        a_q;
  logic signed [31:0] term_q, term_new;
  logic signed [33:0] sum_q, sum_new;
  logic [3:0]         n_q;
  logic [1:0]         k_q;
  logic signed [17:0] cos_q, sin_q;
  logic signed [36:0] u0_q, u1_q;
  logic signed [31:0] r_q, l_q, sat_val;
  logic               out_valid_q;
  logic signed [31:0] out_r_q, out_l_q;

  ddpt_pkg::mul_ctrl_t  mul_ctrl;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [CW-1:0] mul_acc, acc_rnd, acc_sq, p_abs;
  logic                 mul_done;

  logic                 div_go, div_done;
  logic [DW-1:0]        div_num, div_den, div_q;
  logic                 sqrt_go, sqrt_done;
  logic [31:0]          sqrt_r;
  logic                 cor_go, cor_done;
  ddpt_pkg::cor_mode_e  cor_mode;
  logic signed [15:0]   cor_head;
  logic signed [17:0]   cor_cos, cor_sin;

  logic signed [32:0]   ex, ey, dmag;
  logic signed [18:0]   cms, cps;
  logic [16:0]          om_alpha;
  logic [31:0]          vsq;
  logic [32:0]          alpha_rnd;
  logic [15:0]          alpha_new;
  logic                 denom_pos;
  logic [28:0]          sat_hi;

  assign in_ready_o = (state_q == ddpt_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign zero_quat  = (quat_z_i == 16'sd0) && (quat_w_i == 16'sd0);

  assign ex       = 33'(ftx_q) - 33'(robot_x_q);
  assign ey       = 33'(fty_q) - 33'(robot_y_q);
  assign cms      = 19'(cos_q) - 19'(sin_q);
  assign cps      = 19'(sin_q) + 19'(cos_q);
  assign om_alpha = 17'h10000 - {1'b0, alpha_q};

  assign acc_rnd = mul_acc + 76'sd32768;
  assign acc_sq  = mul_acc + 76'sd536870912;
  assign p_abs   = mul_acc[CW-1] ? -mul_acc : mul_acc;
  assign sat_hi  = acc_rnd[75:47];
  assign sat_val = ((&sat_hi) || !(|sat_hi)) ? acc_rnd[47:16]
                 : (acc_rnd[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign dmag      = $signed({1'b0, magg_q}) - $signed({1'b0, sqrt_r});
  assign denom     = (DW'(dmag) <<< 4) + DW'(dmag) + ddpt_pkg::TsBiasQ16;
  assign denom_pos = !denom[DW-1] && (denom != '0);

  assign term_new  = mul_acc[CW-1] ? $signed(div_q[31:0]) : -$signed(div_q[31:0]);
  assign sum_new   = sum_q + 34'(term_new);
  assign vsq       = acc_sq[61:30];
  assign alpha_rnd = {1'b0, vsq} + 33'd8192;
  assign alpha_new = (|alpha_rnd[32:30]) ? ddpt_pkg::AlphaMax : alpha_rnd[29:14];

  always_comb begin
    case (state_q)
      ddpt_pkg::S_HEAD, ddpt_pkg::S_ROT:         unit_done = cor_done;
      ddpt_pkg::S_SQ_G, ddpt_pkg::S_SQ_R:        unit_done = sqrt_done;
      ddpt_pkg::S_DIV_A, ddpt_pkg::S_EXP_DIV:    unit_done = div_done;
      ddpt_pkg::S_IDLE, ddpt_pkg::S_OUT:         unit_done = 1'b0;
      default:                                   unit_done = mul_done;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    launch   = 1'b0;
    mul_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    div_go   = 1'b0;
    div_num  = '0;
    div_den  = '0;
    sqrt_go  = 1'b0;
    cor_go   = 1'b0;
    cor_mode = (state_q == ddpt_pkg::S_HEAD) ? ddpt_pkg::COR_VECTOR : ddpt_pkg::COR_ROTATE;
    if (state_q != ddpt_pkg::S_IDLE && state_q != ddpt_pkg::S_OUT) begin
      launch   = !issued_q;
      issued_d = !unit_done;
    end
    case (state_q)
      ddpt_pkg::S_IDLE: begin
        if (in_fire) begin
          case (ddpt_pkg::req_e'(req_type_i))
            ddpt_pkg::REQ_ODOM: state_d = zero_quat ? ddpt_pkg::S_IDLE : ddpt_pkg::S_HEAD;
            ddpt_pkg::REQ_GOAL: state_d = ddpt_pkg::S_MG_X;
            ddpt_pkg::REQ_TICK: state_d = ddpt_pkg::S_ROT;
            default:            state_d = ddpt_pkg::S_IDLE;
          endcase
        end
      end
      ddpt_pkg::S_HEAD: begin
        cor_go = launch;
        if (unit_done) state_d = ddpt_pkg::S_IDLE;
      end
      ddpt_pkg::S_MG_X: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(goal_x_q);
        mul_b    = BW'(goal_x_q);
        if (unit_done) state_d = ddpt_pkg::S_MG_Y;
      end
      ddpt_pkg::S_MG_Y: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(goal_y_q);
        mul_b    = BW'(goal_y_q);
        if (unit_done) state_d = ddpt_pkg::S_SQ_G;
      end
      ddpt_pkg::S_SQ_G: begin
        sqrt_go = launch;
        if (unit_done) state_d = ddpt_pkg::S_MR_X;
      end
      ddpt_pkg::S_MR_X: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(robot_x_q);
        mul_b    = BW'(robot_x_q);
        if (unit_done) state_d = ddpt_pkg::S_MR_Y;
      end
      ddpt_pkg::S_MR_Y: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(robot_y_q);
        mul_b    = BW'(robot_y_q);
        if (unit_done) state_d = ddpt_pkg::S_SQ_R;
      end
      ddpt_pkg::S_SQ_R: begin
        sqrt_go = launch;
        if (unit_done) state_d = denom_pos ? ddpt_pkg::S_DIV_A : ddpt_pkg::S_IDLE;
      end
      ddpt_pkg::S_DIV_A: begin
        div_go  = launch;
        div_num = ddpt_pkg::ExpNumQ32 + {1'b0, denom_q[DW-1:1]};
        div_den = denom_q;
        if (unit_done) state_d = (|div_q[DW-1:20]) ? ddpt_pkg::S_IDLE : ddpt_pkg::S_EXP_MUL;
      end
      ddpt_pkg::S_EXP_MUL: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(term_q);
        mul_b    = {14'b0, a_q};
        if (unit_done) state_d = ddpt_pkg::S_EXP_DIV;
      end
      ddpt_pkg::S_EXP_DIV: begin
        div_go  = launch;
        div_num = p_abs[59:20];
        div_den = DW'(n_q);
        if (unit_done) begin
          state_d = (n_q == ddpt_pkg::ExpTerms) ? ddpt_pkg::S_SQR : ddpt_pkg::S_EXP_MUL;
        end
      end
      ddpt_pkg::S_SQR: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = {8'b0, v_q};
        mul_b    = {2'b0, v_q};
        if (unit_done && k_q == ddpt_pkg::LastSquare) state_d = ddpt_pkg::S_IDLE;
      end
      ddpt_pkg::S_ROT: begin
        cor_go = launch;
        if (unit_done) state_d = ddpt_pkg::S_FX1;
      end
      ddpt_pkg::S_FX1: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(ftx_q);
        mul_b    = {18'b0, alpha_q};
        if (unit_done) state_d = ddpt_pkg::S_FX2;
      end
      ddpt_pkg::S_FX2: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(goal_x_q);
        mul_b    = {17'b0, om_alpha};
        if (unit_done) state_d = ddpt_pkg::S_FY1;
      end
      ddpt_pkg::S_FY1: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(fty_q);
        mul_b    = {18'b0, alpha_q};
        if (unit_done) state_d = ddpt_pkg::S_FY2;
      end
      ddpt_pkg::S_FY2: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(goal_y_q);
        mul_b    = {17'b0, om_alpha};
        if (unit_done) state_d = ddpt_pkg::S_U0A;
      end
      ddpt_pkg::S_U0A: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(ex);
        mul_b    = BW'(cms);
        if (unit_done) state_d = ddpt_pkg::S_U0B;
      end
      ddpt_pkg::S_U0B: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(ey);
        mul_b    = BW'(cps);
        if (unit_done) state_d = ddpt_pkg::S_U1A;
      end
      ddpt_pkg::S_U1A: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(ey);
        mul_b    = BW'(cos_q);
        if (unit_done) state_d = ddpt_pkg::S_U1B;
      end
      ddpt_pkg::S_U1B: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b1};
        mul_a    = AW'(ex);
        mul_b    = BW'(sin_q);
        if (unit_done) state_d = ddpt_pkg::S_RA;
      end
      ddpt_pkg::S_RA: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(u0_q);
        mul_b    = ddpt_pkg::GainU0Q16;
        if (unit_done) state_d = ddpt_pkg::S_RB;
      end
      ddpt_pkg::S_RB: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b0};
        mul_a    = AW'(u1_q);
        mul_b    = ddpt_pkg::GainU1Q16;
        if (unit_done) state_d = ddpt_pkg::S_LA;
      end
      ddpt_pkg::S_LA: begin
        mul_ctrl = '{go: launch, clr: 1'b1, neg: 1'b0};
        mul_a    = AW'(u0_q);
        mul_b    = ddpt_pkg::GainU0Q16;
        if (unit_done) state_d = ddpt_pkg::S_LB;
      end
      ddpt_pkg::S_LB: begin
        mul_ctrl = '{go: launch, clr: 1'b0, neg: 1'b1};
        mul_a    = AW'(u1_q);
        mul_b    = ddpt_pkg::GainU1Q16;
        if (unit_done) state_d = ddpt_pkg::S_OUT;
      end
      ddpt_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ddpt_pkg::S_IDLE;
      end
      default: begin
        state_d = ddpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ddpt_pkg::S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q   <= '0;
      robot_y_q   <= '0;
      heading_q   <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      alpha_q     <= '0;
      ftx_q       <= '0;
      fty_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ddpt_pkg::S_IDLE: begin
          if (in_fire) begin
            case (ddpt_pkg::req_e'(req_type_i))
              ddpt_pkg::REQ_ODOM: begin
                robot_x_q <= pos_x_i;
                robot_y_q <= pos_y_i;
                if (zero_quat) heading_q <= '0;
              end
              ddpt_pkg::REQ_GOAL: begin
                goal_x_q <= pos_x_i;
                goal_y_q <= pos_y_i;
              end
              default: begin
              end
            endcase
          end
        end
        ddpt_pkg::S_HEAD: begin
          if (unit_done) heading_q <= cor_head;
        end
        ddpt_pkg::S_SQ_R: begin
          if (unit_done && !denom_pos) alpha_q <= ddpt_pkg::AlphaMax;
        end
        ddpt_pkg::S_DIV_A: begin
          if (unit_done && (|div_q[DW-1:20])) alpha_q <= '0;
        end
        ddpt_pkg::S_SQR: begin
          if (unit_done && k_q == ddpt_pkg::LastSquare) alpha_q <= alpha_new;
        end
        ddpt_pkg::S_FX2: begin
          if (unit_done) ftx_q <= acc_rnd[47:16];
        end
        ddpt_pkg::S_FY2: begin
          if (unit_done) fty_q <= acc_rnd[47:16];
        end
        ddpt_pkg::S_OUT: begin
          if (!out_valid_q || out_ready_i) out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      quat_z_q <= quat_z_i;
      quat_w_q <= quat_w_i;
    end
    case (state_q)
      ddpt_pkg::S_SQ_G: begin
        if (unit_done) magg_q <= sqrt_r;
      end
      ddpt_pkg::S_SQ_R: begin
        if (unit_done) denom_q <= denom;
      end
      ddpt_pkg::S_DIV_A: begin
        if (unit_done) begin
          a_q    <= div_q[19:0];
          term_q <= ddpt_pkg::ExpOneQ30;
          sum_q  <= 34'(ddpt_pkg::ExpOneQ30);
          n_q    <= 4'd1;
        end
      end
      ddpt_pkg::S_EXP_DIV: begin
        if (unit_done) begin
          term_q <= term_new;
          sum_q  <= sum_new;
          n_q    <= n_q + 4'd1;
          v_q    <= sum_new[33] ? 32'd0 : sum_new[31:0];
          k_q    <= '0;
        end
      end
      ddpt_pkg::S_SQR: begin
        if (unit_done) begin
          v_q <= vsq;
          k_q <= k_q + 2'd1;
        end
      end
      ddpt_pkg::S_ROT: begin
        if (unit_done) begin
          cos_q <= cor_cos;
          sin_q <= cor_sin;
        end
      end
      ddpt_pkg::S_U0B: begin
        if (unit_done) u0_q <= acc_rnd[52:16];
      end
      ddpt_pkg::S_U1B: begin
        if (unit_done) u1_q <= acc_rnd[52:16];
      end
      ddpt_pkg::S_RB: begin
        if (unit_done) r_q <= sat_val;
      end
      ddpt_pkg::S_LB: begin
        if (unit_done) l_q <= sat_val;
      end
      ddpt_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_r_q <= r_q;
          out_l_q <= l_q;
        end
      end
      default: begin
      end
    endcase
  end

  ddpt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .acc_o  (mul_acc),
    .done_o (mul_done)
  );

  ddpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_q),
    .done_o  (div_done)
  );

  ddpt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .val_i   (mul_acc[63:0]),
    .root_o  (sqrt_r),
    .done_o  (sqrt_done)
  );

  ddpt_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cor_go),
    .mode_i   (cor_mode),
    .quat_z_i (quat_z_q),
    .quat_w_i (quat_w_q),
    .head_i   (heading_q),
    .head_o   (cor_head),
    .cos_o    (cor_cos),
    .sin_o    (cor_sin),
    .done_o   (cor_done)
  );

  assign out_valid_o         = out_valid_q;
  assign right_wheel_speed_o = out_r_q;
  assign left_wheel_speed_o  = out_l_q;

endmodule

/* bench/tb_diff_drive_pose_tracker.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the differential-drive pose tracker with a fixed-point predictor.
module tb_diff_drive_pose_tracker;
  import ddpt_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int RandomWords = 1030;
  localparam int HoldOffAt = 30;
  localparam int HoldOffCycles = 20000;

  typedef struct {
    logic [1:0] req;
    int         px;
    int         py;
    shortint    qz;
    shortint    qw;
    bit         fixed;
    int         er;
    int         el;
  } stim_row_t;

  typedef struct {
    int right;
    int left;
  } speeds_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [15:0] quat_z_i;
  logic signed [15:0] quat_w_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] right_wheel_speed_o;
  logic signed [31:0] left_wheel_speed_o;

  diff_drive_pose_tracker dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .pos_x_i,
    .pos_y_i,
    .quat_z_i,
    .quat_w_i,
    .out_valid_o,
    .out_ready_i,
    .right_wheel_speed_o,
    .left_wheel_speed_o
  );

  localparam longint AtanQ16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};

  int      trk_robot_x, trk_robot_y, trk_goal_x, trk_goal_y;
  int      trk_target_x, trk_target_y, trk_alpha;
  shortint trk_heading;

  speeds_t   speeds_pending[$];
  stim_row_t rows[$];
  int        errors;
  int        n_got;
  bit        quiet_in, quiet_out;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vec_len(int x, int y);
    longint unsigned xx, yy;
    xx = longint'(x) * longint'(x);
    yy = longint'(y) * longint'(y);
    return longint'(int_sqrt(xx + yy));
  endfunction

  function automatic shortint heading_from_quat(shortint qz, shortint qw);
    longint x, y, ang, a2, xn, yn;
    x = longint'(qw) * 65536;
    y = longint'(qz) * 65536;
    ang = 0;
    if (qz == 0 && qw == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        ang = ang + AtanQ16[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        ang = ang - AtanQ16[i];
      end
      x = xn;
      y = yn;
    end
    a2 = 2 * ang;
    if (a2 > 205887) a2 = a2 - 411774;
    if (a2 < -205887) a2 = a2 + 411774;
    return shortint'((a2 + 4) >>> 3);
  endfunction

  task automatic heading_cos_sin(input shortint h, output longint c, output longint s);
    longint z, x, y, xn, yn;
    bit neg;
    z = longint'(h) * 8;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 102944) begin
      z = z - 205887;
      neg = 1;
    end else if (z < -102944) begin
      z = z + 205887;
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z = z - AtanQ16[i];
      end else begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z = z + AtanQ16[i];
      end
      x = xn;
      y = yn;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  function automatic int decay_factor(longint a);
    longint term, sum;
    longint unsigned v;
    term = 64'sd1 << 30;
    sum = term;
    if (a >= (64'sd1 << 20)) return 0;
    for (int n = 1; n <= 12; n++) begin
      term = -(term * a) / (longint'(n) << 20);
      sum = sum + term;
    end
    v = (sum > 0) ? longint'(sum) : 0;
    for (int n = 0; n < 4; n++) v = (v * v + (64'd1 << 29)) >> 30;
    v = (v + 8192) >> 14;
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic int low_pass(int old, int goal, int alpha);
    longint acc;
    acc = longint'(old) * longint'(alpha) + longint'(goal) * longint'(65536 - alpha);
    return int'((acc + 32768) >>> 16);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  task automatic track_word(input stim_row_t w, output bit has_out, output speeds_t sp);
    longint d, denom, ex, ey, c, s, u0, u1;
    has_out = 0;
    sp = '{0, 0};
    case (w.req)
      REQ_ODOM: begin
        trk_robot_x = w.px;
        trk_robot_y = w.py;
        trk_heading = heading_from_quat(w.qz, w.qw);
      end
      REQ_GOAL: begin
        trk_goal_x = w.px;
        trk_goal_y = w.py;
        d = vec_len(trk_goal_x, trk_goal_y) - vec_len(trk_robot_x, trk_robot_y);
        denom = 6554 + 17 * d;
        if (denom <= 0) trk_alpha = 65535;
        else trk_alpha = decay_factor((171798692 + denom / 2) / denom);
      end
      REQ_TICK: begin
        trk_target_x = low_pass(trk_target_x, trk_goal_x, trk_alpha);
        trk_target_y = low_pass(trk_target_y, trk_goal_y, trk_alpha);
        ex = longint'(trk_target_x) - longint'(trk_robot_x);
        ey = longint'(trk_target_y) - longint'(trk_robot_y);
        heading_cos_sin(trk_heading, c, s);
        u0 = (ex * (c - s) + ey * (s + c) + 32768) >>> 16;
        u1 = (ey * c - ex * s + 32768) >>> 16;
        sp.right = clip32((u0 * 873813 + u1 * 140684 + 32768) >>> 16);
        sp.left = clip32((u0 * 873813 - u1 * 140684 + 32768) >>> 16);
        has_out = 1;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input stim_row_t w);
    int idle;
    bit has_out;
    speeds_t sp;
    idle = quiet_in ? 0 : $urandom_range(0, 17);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= w.req;
    pos_x_i <= w.px;
    pos_y_i <= w.py;
    quat_z_i <= w.qz;
    quat_w_i <= w.qw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_word(w, has_out, sp);
    if (has_out) begin
      if (w.fixed) sp = '{w.er, w.el};
      speeds_pending.push_back(sp);
    end
  endtask

  task automatic add_row(logic [1:0] req, int px, int py, shortint qz, shortint qw,
                         bit fixed = 0, int er = 0, int el = 0);
    rows.push_back('{req, px, py, qz, qw, fixed, er, el});
  endtask

  function automatic int rand_pos();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(0, 1310720)) - 655360;
    endcase
  endfunction

  function automatic shortint rand_quat();
    if ($urandom_range(0, 4) == 0) return shortint'($urandom);
    return shortint'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int idle;
    speeds_t want;
    out_ready_i <= 1'b0;
    n_got = 0;
    @(posedge rst_ni);
    forever begin
      idle = quiet_out ? 0 : $urandom_range(0, 17);
      if (n_got == HoldOffAt) idle = HoldOffCycles;
      if (idle > 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      n_got++;
      if (speeds_pending.size() == 0) begin
        $display("%0t: unexpected word right=%0d left=%0d", $time,
                 right_wheel_speed_o, left_wheel_speed_o);
        errors++;
      end else begin
        want = speeds_pending.pop_front();
        if (right_wheel_speed_o !== want.right) begin
          $display("%0t: right speed expected %0d actual %0d", $time, want.right,
                   right_wheel_speed_o);
          errors++;
        end
        if (left_wheel_speed_o !== want.left) begin
          $display("%0t: left speed expected %0d actual %0d", $time, want.left,
                   left_wheel_speed_o);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t w;
    int pick;
    errors = 0;
    quiet_in = 0;
    quiet_out = 0;
    trk_robot_x = 0;
    trk_robot_y = 0;
    trk_heading = 0;
    trk_goal_x = 0;
    trk_goal_y = 0;
    trk_alpha = 0;
    trk_target_x = 0;
    trk_target_y = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_ODOM;
    pos_x_i <= '0;
    pos_y_i <= '0;
    quat_z_i <= '0;
    quat_w_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0);
    add_row(ReqUnused, 32'sh12345678, -5, -7, 9);
    add_row(REQ_ODOM, 0, 0, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0);
    add_row(REQ_GOAL, 655360, 0, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_ODOM, 32'sh7fffffff, 32'sh80000000, 16384, 0);
    add_row(REQ_GOAL, 32'sh80000000, 32'sh7fffffff, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_ODOM, 655360, 0, 0, -16384);
    add_row(REQ_GOAL, 0, 0, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_ODOM, 1000, 0, -32768, 32767);
    add_row(REQ_GOAL, 620, 0, 0, 0);
    add_row(REQ_TICK, -1, -1, -1, -1);
    add_row(REQ_GOAL, 32'sh40000000, 32'sh40000000, 0, 0);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_ODOM, -655360, 327680, -16384, -1);
    add_row(REQ_TICK, 0, 0, 0, 0);
    add_row(REQ_ODOM, 0, 0, 11585, 11585);
    add_row(REQ_TICK, 0, 0, 0, 0);
    foreach (rows[i]) send_word(rows[i]);

    for (int i = 0; i < RandomWords; i++) begin
      if (i % 64 == 0) begin
        quiet_in = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) w.req = REQ_ODOM;
      else if (pick < 45) w.req = REQ_GOAL;
      else if (pick < 95) w.req = REQ_TICK;
      else w.req = ReqUnused;
      w.px = rand_pos();
      w.py = rand_pos();
      w.qz = rand_quat();
      w.qw = rand_quat();
      w.fixed = 0;
      w.er = 0;
      w.el = 0;
      send_word(w);
    end
    in_valid_i <= 1'b0;

    while (speeds_pending.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
